// ----- rtl/table_linear_interpolator_top_defines.svh -----
// Assertion macros shared by the interpolator RTL.
// Depends on nothing; the asserting modules must have clk_i and rst_ni.
`ifndef TABLE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tli_pkg.sv -----
// Shared types, constants and helper functions of the interpolator.
// Depends on nothing; used by every module of the block.
package tli_pkg;

  localparam int TableDepth = 32;
  localparam int ValueBits  = 24;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CfgW       = 6;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);
  // Magnitude of a difference of two table values, quotient width kept before
  // saturation, and the width of the final signed sum.
  localparam int MagW       = ValueBits;
  localparam int ProdW      = 2 * MagW;
  localparam int QuoW       = MagW + 1;
  localparam int CntW       = $clog2(QuoW);
  localparam int SumW       = QuoW + 2;

  localparam logic signed [ValueBits-1:0] VMax = {1'b0, {(ValueBits - 1){1'b1}}};
  localparam logic signed [ValueBits-1:0] VMin = {1'b1, {(ValueBits - 1){1'b0}}};

  typedef enum logic {
    K_LOOKUP = 1'b0,
    K_WRITE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_INTERP = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2
  } region_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ0,
    S_LOW,
    S_HIGH,
    S_SEARCH,
    S_PROBE,
    S_FETCHHI,
    S_SETUP,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FINISH
  } state_e;

  typedef struct packed {
    kind_e                       kind;
    logic [IdxW-1:0]             idx;
    logic signed [ValueBits-1:0] x;
    logic signed [ValueBits-1:0] y;
  } item_t;

  // Absolute value of a signed difference; it always fits in MagW bits.
  function automatic logic [MagW-1:0] mag_of(input logic signed [ValueBits:0] v);
    logic [ValueBits:0] a;
    a = v[ValueBits] ? $unsigned(-v) : $unsigned(v);
    return a[MagW-1:0];
  endfunction

  // Clamp a wide signed sum into the signed value range.
  function automatic logic signed [ValueBits-1:0] sat(input logic signed [SumW-1:0] v);
    logic signed [ValueBits-1:0] r;
    if (v > SumW'(VMax)) begin
      r = VMax;
    end else if (v < SumW'(VMin)) begin
      r = VMin;
    end else begin
      r = v[ValueBits-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/tli_front.sv -----
// Front end: accepts items, tags them as lookup or write and queues them.
// Depends on tli_pkg and the assertion macro header.
`include "table_linear_interpolator_top_defines.svh"

module tli_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 cmd_i,
  input  logic [tli_pkg::IdxW-1:0]             point_index_i,
  input  logic signed [tli_pkg::ValueBits-1:0] x_value_i,
  input  logic signed [tli_pkg::ValueBits-1:0] y_value_i,
  input  logic                                 pop_i,
  output tli_pkg::item_t                       item_o,
  output logic                                 empty_o
);

  tli_pkg::item_t             slot_q [tli_pkg::QueueDepth];
  logic [tli_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [tli_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [tli_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       push;
  tli_pkg::item_t             incoming;

  assign busy_o  = (cnt_q == tli_pkg::QCntW'(tli_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign push    = start_i & ~busy_o;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    incoming.kind = cmd_i ? tli_pkg::K_WRITE : tli_pkg::K_LOOKUP;
    incoming.idx  = point_index_i;
    incoming.x    = x_value_i;
    incoming.y    = y_value_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tli_pkg::QPtrW'(tli_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + tli_pkg::QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == tli_pkg::QPtrW'(tli_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + tli_pkg::QPtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + tli_pkg::QCntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - tli_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

  `TLI_ASSERT(a_no_pop_empty, !(pop_i && cnt_q == '0), "item popped from an empty queue")
  `TLI_ASSERT(a_cnt_range, cnt_q <= tli_pkg::QCntW'(tli_pkg::QueueDepth), "queue count overflow")
  `TLI_ASSERT_NEXT(a_push_count, push && !pop_i, cnt_q == $past(cnt_q) + tli_pkg::QCntW'(1), "push lost")

endmodule

// ----- rtl/tli_back.sv -----
// Back end: breakpoint memory, search sequencer, multiplier and serial divider.
// Depends on tli_pkg and the assertion macro header.
`include "table_linear_interpolator_top_defines.svh"

module tli_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tli_pkg::item_t                       item_i,
  input  logic                                 empty_i,
  output logic                                 pop_o,
  input  logic [tli_pkg::CfgW-1:0]             points_i,
  output logic                                 idle_o,
  output logic signed [tli_pkg::ValueBits-1:0] y_out_o,
  output logic [1:0]                           region_o,
  output logic                                 done_o
);

  // Breakpoint memories with registered read data.
  logic signed [tli_pkg::ValueBits-1:0] xmem [tli_pkg::TableDepth];
  logic signed [tli_pkg::ValueBits-1:0] ymem [tli_pkg::TableDepth];
  logic signed [tli_pkg::ValueBits-1:0] rdx_q, rdy_q;
  logic [tli_pkg::IdxW-1:0]             rd_addr;
  logic                                 mem_we;

  tli_pkg::state_e                      state_q, state_d;
  logic                                 done_q, done_d;
  logic                                 searching;
  logic [tli_pkg::IdxW-1:0]             lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [tli_pkg::IdxW-1:0]             last_q, last_d;
  logic signed [tli_pkg::ValueBits-1:0] xin_q, xin_d, xl_q, xl_d, yl_q, yl_d;
  logic signed [tli_pkg::ValueBits-1:0] yout_q, yout_d;
  tli_pkg::region_e                     region_q, region_d;
  logic [tli_pkg::MagW-1:0]             den_q, den_d, mnum_q, mnum_d, mdy_q, mdy_d;
  logic                                 neg_q, neg_d, ovf_q, ovf_d;
  logic [tli_pkg::ProdW-1:0]            prod_q, prod_d;
  logic [tli_pkg::MagW-1:0]             rem_q, rem_d;
  logic [tli_pkg::QuoW-1:0]             dvd_q, dvd_d;
  logic [tli_pkg::CntW-1:0]             cnt_q, cnt_d;

  assign idle_o    = (state_q == tli_pkg::S_IDLE);
  assign y_out_o   = yout_q;
  assign region_o  = region_q;
  assign done_o    = done_q;
  assign searching = (state_q == tli_pkg::S_SEARCH) || (state_q == tli_pkg::S_PROBE);

  always_comb begin
    logic [tli_pkg::IdxW:0]             mid_sum;
    logic [tli_pkg::IdxW-1:0]           lo_eff;
    logic signed [tli_pkg::ValueBits:0] den_s, num_s, dy_s;
    logic [tli_pkg::MagW:0]             trial;
    logic                               ge;
    logic signed [tli_pkg::SumW-1:0]    sum;

    mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
    lo_eff   = (lo_q == '0) ? tli_pkg::IdxW'(1) : lo_q;
    den_s    = {rdx_q[tli_pkg::ValueBits-1], rdx_q} - {xl_q[tli_pkg::ValueBits-1], xl_q};
    num_s    = {xin_q[tli_pkg::ValueBits-1], xin_q} - {xl_q[tli_pkg::ValueBits-1], xl_q};
    dy_s     = {rdy_q[tli_pkg::ValueBits-1], rdy_q} - {yl_q[tli_pkg::ValueBits-1], yl_q};
    trial    = {rem_q, dvd_q[tli_pkg::QuoW-1]};
    ge       = (trial >= {1'b0, den_q});
    sum      = neg_q ? (tli_pkg::SumW'(yl_q) - $signed({2'b00, dvd_q}))
                     : (tli_pkg::SumW'(yl_q) + $signed({2'b00, dvd_q}));

    state_d  = state_q;
    done_d   = 1'b0;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    last_d   = last_q;
    xin_d    = xin_q;
    xl_d     = xl_q;
    yl_d     = yl_q;
    yout_d   = yout_q;
    region_d = region_q;
    den_d    = den_q;
    mnum_d   = mnum_q;
    mdy_d    = mdy_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    cnt_d    = cnt_q;
    rd_addr  = '0;
    mem_we   = 1'b0;
    pop_o    = 1'b0;

    unique case (state_q)
      tli_pkg::S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (item_i.kind == tli_pkg::K_WRITE) begin
            mem_we = 1'b1;
          end else begin
            xin_d = item_i.x;
            if (points_i == '0) begin
              last_d = '0;
            end else if (points_i > tli_pkg::CfgW'(tli_pkg::TableDepth)) begin
              last_d = tli_pkg::IdxW'(tli_pkg::TableDepth - 1);
            end else begin
              last_d = tli_pkg::IdxW'(points_i - tli_pkg::CfgW'(1));
            end
            state_d = tli_pkg::S_READ0;
          end
        end
      end
      tli_pkg::S_READ0: begin
        rd_addr = '0;
        state_d = tli_pkg::S_LOW;
      end
      tli_pkg::S_LOW: begin
        if (xin_q <= rdx_q) begin
          yout_d   = rdy_q;
          region_d = tli_pkg::REG_LOW;
          done_d   = 1'b1;
          state_d  = tli_pkg::S_IDLE;
        end else begin
          rd_addr = last_q;
          state_d = tli_pkg::S_HIGH;
        end
      end
      tli_pkg::S_HIGH: begin
        if (xin_q >= rdx_q) begin
          yout_d   = rdy_q;
          region_d = tli_pkg::REG_HIGH;
          done_d   = 1'b1;
          state_d  = tli_pkg::S_IDLE;
        end else begin
          lo_d    = '0;
          hi_d    = last_q;
          state_d = tli_pkg::S_SEARCH;
        end
      end
      tli_pkg::S_SEARCH: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[tli_pkg::IdxW:1];
          rd_addr = mid_sum[tli_pkg::IdxW:1];
          state_d = tli_pkg::S_PROBE;
        end else begin
          lo_d    = lo_eff;
          rd_addr = lo_eff - tli_pkg::IdxW'(1);
          state_d = tli_pkg::S_FETCHHI;
        end
      end
      tli_pkg::S_PROBE: begin
        if (rdx_q < xin_q) begin
          lo_d = mid_q + tli_pkg::IdxW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = tli_pkg::S_SEARCH;
      end
      tli_pkg::S_FETCHHI: begin
        xl_d    = rdx_q;
        yl_d    = rdy_q;
        rd_addr = lo_q;
        state_d = tli_pkg::S_SETUP;
      end
      tli_pkg::S_SETUP: begin
        if (den_s == '0) begin
          yout_d   = yl_q;
          region_d = tli_pkg::REG_INTERP;
          done_d   = 1'b1;
          state_d  = tli_pkg::S_IDLE;
        end else begin
          den_d   = tli_pkg::mag_of(den_s);
          mnum_d  = tli_pkg::mag_of(num_s);
          mdy_d   = tli_pkg::mag_of(dy_s);
          neg_d   = num_s[tli_pkg::ValueBits] ^ dy_s[tli_pkg::ValueBits]
                    ^ den_s[tli_pkg::ValueBits];
          state_d = tli_pkg::S_MUL;
        end
      end
      tli_pkg::S_MUL: begin
        prod_d  = mnum_q * mdy_q;
        state_d = tli_pkg::S_PREP;
      end
      tli_pkg::S_PREP: begin
        // The upper product bits start as the partial remainder. If they
        // already reach the divisor, the quotient is too large for any
        // result to escape saturation.
        rem_d   = tli_pkg::MagW'(prod_q >> tli_pkg::QuoW);
        dvd_d   = prod_q[tli_pkg::QuoW-1:0];
        ovf_d   = (tli_pkg::MagW'(prod_q >> tli_pkg::QuoW) >= den_q);
        cnt_d   = '0;
        state_d = (tli_pkg::MagW'(prod_q >> tli_pkg::QuoW) >= den_q) ? tli_pkg::S_FINISH
                  : tli_pkg::S_DIV;
      end
      tli_pkg::S_DIV: begin
        rem_d = ge ? tli_pkg::MagW'(trial - {1'b0, den_q}) : tli_pkg::MagW'(trial);
        dvd_d = {dvd_q[tli_pkg::QuoW-2:0], ge};
        cnt_d = cnt_q + tli_pkg::CntW'(1);
        if (cnt_q == tli_pkg::CntW'(tli_pkg::QuoW - 1)) begin
          state_d = tli_pkg::S_FINISH;
        end
      end
      tli_pkg::S_FINISH: begin
        if (ovf_q) begin
          yout_d = neg_q ? tli_pkg::VMin : tli_pkg::VMax;
        end else begin
          yout_d = tli_pkg::sat(sum);
        end
        region_d = tli_pkg::REG_INTERP;
        done_d   = 1'b1;
        state_d  = tli_pkg::S_IDLE;
      end
      default: begin
        state_d = tli_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tli_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    last_q   <= last_d;
    xin_q    <= xin_d;
    xl_q     <= xl_d;
    yl_q     <= yl_d;
    yout_q   <= yout_d;
    region_q <= region_d;
    den_q    <= den_d;
    mnum_q   <= mnum_d;
    mdy_q    <= mdy_d;
    neg_q    <= neg_d;
    ovf_q    <= ovf_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    cnt_q    <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      xmem[item_i.idx] <= item_i.x;
      ymem[item_i.idx] <= item_i.y;
    end
    rdx_q <= xmem[rd_addr];
    rdy_q <= ymem[rd_addr];
  end

  `TLI_ASSERT(a_search_order, !searching || lo_q <= hi_q, "search bounds crossed")
  `TLI_ASSERT(a_done_idle, !done_q || state_q == tli_pkg::S_IDLE, "result while sequencer busy")
  `TLI_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")

endmodule

// ----- rtl/table_linear_interpolator_top.sv -----
// Top level of the piecewise linear interpolation table.
// Depends on tli_pkg, tli_front and tli_back.

// An item is taken at a rising edge where start is high and busy is low. A
// write item (cmd_i high) stores one breakpoint and gives no result. A lookup
// item (cmd_i low) gives exactly one result, presented on y_out_o and region_o
// for one cycle while done_o is high; the receiver cannot stall, so it must
// take each result in that cycle. Items pass through a two-entry queue, so the
// block keeps taking items while the back end works, and busy rises only when
// that queue is full. A write item is stored while the back end stays idle.
// A lookup reads entry 0 and clamps low if x is at or below it, then reads
// the last entry in use and clamps high if x is at or above it; else a binary
// search, each probe through the registered memory read, finds the segment,
// and a multiply and a restoring divider, one quotient bit a cycle for a
// 25-bit quotient, interpolate in it. The result strobe is registered and
// rises in the cycle after the back end's last state. Breakpoint entries
// are undefined until written; the x entries in use must be written before
// lookups use them. points_in_use is written over its own valid/ready port,
// taken only while the block holds no item; 0 acts as 1, values above 32 as 32.
module table_linear_interpolator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cmd_i,
  input  logic [tli_pkg::IdxW-1:0]             point_index_i,
  input  logic signed [tli_pkg::ValueBits-1:0] x_value_i,
  input  logic signed [tli_pkg::ValueBits-1:0] y_value_i,
  output logic signed [tli_pkg::ValueBits-1:0] y_out_o,
  output logic [1:0]                           region_o,
  output logic                                 done_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tli_pkg::CfgW-1:0]             cfg_data_i
);

  tli_pkg::item_t            item;
  logic                      q_empty;
  logic                      pop;
  logic                      back_idle;
  logic [tli_pkg::CfgW-1:0]  points_q, points_d;

  // The count register changes only when nothing is queued or in flight, so
  // a lookup always sees the value set before it was issued.
  assign cfg_ready_o = back_idle & q_empty;

  always_comb begin
    points_d = points_q;
    if (cfg_valid_i && cfg_ready_o) begin
      points_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= tli_pkg::CfgW'(1);
    end else begin
      points_q <= points_d;
    end
  end

  tli_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .cmd_i         (cmd_i),
    .point_index_i (point_index_i),
    .x_value_i     (x_value_i),
    .y_value_i     (y_value_i),
    .pop_i         (pop),
    .item_o        (item),
    .empty_o       (q_empty)
  );

  tli_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .empty_i  (q_empty),
    .pop_o    (pop),
    .points_i (points_q),
    .idle_o   (back_idle),
    .y_out_o  (y_out_o),
    .region_o (region_o),
    .done_o   (done_o)
  );

endmodule
